/* design/qnsfd_pkg.sv */
// Package for the quoted-name / decimal-size record deframer.
// Holds the parse modes, result kinds, character codes and field widths.
// No dependencies.
package qnsfd_pkg;

  localparam int SizeBitsDef = 40;
  localparam int FileSizeW   = 40;
  localparam int KindW       = 3;
  localparam int ByteW       = 8;

  localparam logic [ByteW-1:0] ChQuote = 8'h22;
  localparam logic [ByteW-1:0] ChB     = 8'h62;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;

  typedef enum logic [2:0] {
    MODE_OPEN  = 3'd0,
    MODE_NAME  = 3'd1,
    MODE_SIZE0 = 3'd2,
    MODE_SIZEN = 3'd3,
    MODE_DATA  = 3'd4,
    MODE_ERR   = 3'd5
  } mode_e;

  typedef enum logic [KindW-1:0] {
    KIND_DELIM = 3'd0,
    KIND_NAME  = 3'd1,
    KIND_DIGIT = 3'd2,
    KIND_HDR   = 3'd3,
    KIND_DATA  = 3'd4,
    KIND_ERR   = 3'd5
  } kind_e;

endpackage

/* design/quoted_name_size_file_deframer_top.sv */
// Quoted-name / decimal-size record deframer, top level.
// The result of an input transfer is registered and shows on the master side in the next cycle.
// Throughput: one byte per cycle while the master side is ready; each byte needs one mode update and one
// ten-times accumulate, both done before the result register.
// Reset (rst_ni low, asynchronous): expect an opening quote, size and count
// cleared, no result pending. Depends on qnsfd_pkg.
module quoted_name_size_file_deframer_top #(
  parameter int SIZE_BITS = qnsfd_pkg::SizeBitsDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [7:0] data_byte
  input  logic [qnsfd_pkg::ByteW-1:0]            s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // [7:0] out_byte, [47:8] file_size
  output logic [qnsfd_pkg::ByteW+qnsfd_pkg::FileSizeW-1:0] m_axis_tdata,
  // [2:0] kind
  output logic [qnsfd_pkg::KindW-1:0]            m_axis_tuser,
  // file_end
  output logic                                   m_axis_tlast
);
  import qnsfd_pkg::*;

  localparam int WideW = SIZE_BITS + 4;
  localparam int ExtW  = (SIZE_BITS > FileSizeW) ? SIZE_BITS : FileSizeW;

  // Parser state
  mode_e                mode_q, mode_d;
  logic [SIZE_BITS-1:0] size_accum_q, size_accum_d;
  logic [SIZE_BITS-1:0] bytes_left_q, bytes_left_d;

  // Result register
  logic                 out_valid_q;
  kind_e                kind_q, kind_d;
  logic [ByteW-1:0]     obyte_q, obyte_d;
  logic [FileSizeW-1:0] fsize_q, fsize_d;
  logic                 fend_q, fend_d;

  logic                 accept;
  logic                 is_digit;
  logic [WideW-1:0]     acc_wide;
  logic [WideW-1:0]     acc_next;
  logic                 overflow;
  logic [ExtW-1:0]      acc_ext;

  // Accept whenever the result register is empty or being drained this cycle
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign is_digit = s_axis_tdata inside {[ChZero:ChNine]};

  // size * 10 + digit, as two shifts and an add; overflow shows in the top bits
  assign acc_wide = WideW'(size_accum_q);
  assign acc_next = (acc_wide << 3) + (acc_wide << 1) + WideW'(s_axis_tdata[3:0]);
  assign overflow = |acc_next[WideW-1:SIZE_BITS];

  // file_size carries the low bits of the parsed size
  assign acc_ext = ExtW'(size_accum_q);

  // Next state of the parser
  always_comb begin
    mode_d       = mode_q;
    size_accum_d = size_accum_q;
    bytes_left_d = bytes_left_q;
    case (mode_q)
      MODE_OPEN: begin
        mode_d = (s_axis_tdata == ChQuote) ? MODE_NAME : MODE_ERR;
      end
      MODE_NAME: begin
        if (s_axis_tdata == ChQuote) begin
          size_accum_d = '0;
          mode_d       = MODE_SIZE0;
        end
      end
      MODE_SIZE0, MODE_SIZEN: begin
        if (is_digit) begin
          if (overflow) begin
            mode_d = MODE_ERR;
          end else begin
            size_accum_d = acc_next[SIZE_BITS-1:0];
            mode_d       = MODE_SIZEN;
          end
        end else if (s_axis_tdata == ChB && mode_q == MODE_SIZEN) begin
          if (size_accum_q == '0) begin
            mode_d = MODE_OPEN;
          end else begin
            bytes_left_d = size_accum_q;
            mode_d       = MODE_DATA;
          end
        end else begin
          mode_d = MODE_ERR;
        end
      end
      MODE_DATA: begin
        // Last payload byte when one or fewer remain
        if (bytes_left_q <= SIZE_BITS'(1)) begin
          bytes_left_d = '0;
          mode_d       = MODE_OPEN;
        end else begin
          bytes_left_d = bytes_left_q - SIZE_BITS'(1);
        end
      end
      default: begin
        mode_d = MODE_ERR;
      end
    endcase
  end

  // Classification of the current byte
  always_comb begin
    kind_d  = KIND_ERR;
    obyte_d = '0;
    fsize_d = '0;
    fend_d  = 1'b0;
    case (mode_q)
      MODE_OPEN: begin
        if (s_axis_tdata == ChQuote) begin
          kind_d = KIND_DELIM;
        end
      end
      MODE_NAME: begin
        if (s_axis_tdata == ChQuote) begin
          kind_d = KIND_DELIM;
        end else begin
          kind_d  = KIND_NAME;
          obyte_d = s_axis_tdata;
        end
      end
      MODE_SIZE0, MODE_SIZEN: begin
        if (is_digit) begin
          if (!overflow) begin
            kind_d  = KIND_DIGIT;
            obyte_d = s_axis_tdata;
          end
        end else if (s_axis_tdata == ChB && mode_q == MODE_SIZEN) begin
          kind_d  = KIND_HDR;
          fsize_d = acc_ext[FileSizeW-1:0];
          fend_d  = (size_accum_q == '0);
        end
      end
      MODE_DATA: begin
        kind_d  = KIND_DATA;
        obyte_d = s_axis_tdata;
        fend_d  = (bytes_left_q <= SIZE_BITS'(1));
      end
      default: begin
        kind_d = KIND_ERR;
      end
    endcase
  end

  // Control state: advance on each input transfer; the valid flag also clears when the result is drained
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_OPEN;
      size_accum_q <= '0;
      bytes_left_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        mode_q       <= mode_d;
        size_accum_q <= size_accum_d;
        bytes_left_q <= bytes_left_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: load on transfer, hold otherwise
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_d;
      obyte_q <= obyte_d;
      fsize_q <= fsize_d;
      fend_q  <= fend_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {fsize_q, obyte_q};
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = fend_q;

`ifndef SYNTHESIS
  // The error state is sticky
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_ERR |=> mode_q == MODE_ERR)
    else $error("error state left without reset");

  // A payload count only exists while payload is being passed
  a_left_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != MODE_DATA |-> bytes_left_q == '0)
    else $error("bytes left outside payload");

  // End of file only on a header or payload byte
  a_end_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |->
      (m_axis_tuser == KIND_HDR || m_axis_tuser == KIND_DATA))
    else $error("file end on wrong kind");

  // An empty file reports a zero size
  a_empty_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast && m_axis_tuser == KIND_HDR |->
      m_axis_tdata[ByteW+FileSizeW-1:ByteW] == '0)
    else $error("empty file with nonzero size");
`endif

endmodule
